[src/dnsqp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dnsqp_pkg;

  // message field limits
  localparam int unsigned MAX_LABEL   = 63;
  localparam logic [15:0] CLASS_INET  = 16'd1;
  localparam logic [7:0]  DOT_CHAR    = 8'h2E;
  localparam logic [8:0]  CAP_MAX     = 9'd256;
  localparam logic [8:0]  CAP_RESET   = 9'd256;

  // header byte offsets
  localparam logic [3:0]  HDR_ID_HI   = 4'd0;
  localparam logic [3:0]  HDR_ID_LO   = 4'd1;
  localparam logic [3:0]  HDR_FLAGS   = 4'd2;
  localparam logic [3:0]  HDR_QD_HI   = 4'd4;
  localparam logic [3:0]  HDR_QD_LO   = 4'd5;
  localparam logic [3:0]  HDR_LAST    = 4'd11;

  // question tail byte offsets
  localparam logic [1:0]  TAIL_TYPE_HI  = 2'd0;
  localparam logic [1:0]  TAIL_TYPE_LO  = 2'd1;
  localparam logic [1:0]  TAIL_CLASS_HI = 2'd2;
  localparam logic [1:0]  TAIL_CLASS_LO = 2'd3;

  // register map
  localparam int unsigned PADDR_W           = 2;
  localparam logic [PADDR_W-1:0] REG_NAME_CAPACITY = 2'd0;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_LEN    = 3'd1,
    PH_CHARS  = 3'd2,
    PH_TAIL   = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OVF     = 2'd1,
    ST_INVALID = 2'd2,
    ST_TOOLONG = 2'd3
  } status_t;

  typedef enum logic {
    KIND_CHAR    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       end_of_msg;
  } msg_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  name_char;
    logic [7:0]  name_length;
    logic [15:0] query_id;
    logic [15:0] query_type;
    logic [1:0]  status;
  } result_t;

endpackage

`default_nettype wire

[src/dns_query_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// each result is registered in the output register, or in the skid entry if that stalls
// throughput: one message byte per cycle while byte_stall is low, parsed combinationally
// output backpressure is absorbed by one skid entry; bytes are held off only when it is full
// reset: clears parser state and output, cap_reg returns to 256

module dns_query_parser (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          byte_valid,
  output logic                               byte_stall,
  input  wire dnsqp_pkg::msg_t               byte_data,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output dnsqp_pkg::result_t                 result_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dnsqp_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import dnsqp_pkg::*;

  logic       name_capacity;
  logic [8:0] cap_reg;
  logic [8:0] cap_eff;
  logic       busy;
  logic       accept;
  logic       produce;
  result_t    result;

  // configuration register
  assign pready        = 1'b1;
  assign name_capacity = psel && penable && pwrite && (paddr == REG_NAME_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= CAP_RESET;
    end else if (name_capacity) begin
      cap_reg <= pwdata[8:0];
    end
  end

  assign prdata  = (paddr == REG_NAME_CAPACITY) ? {23'd0, cap_reg} : 32'd0;
  assign cap_eff = (cap_reg > CAP_MAX) ? CAP_MAX : cap_reg;

  // byte request handshake
  assign byte_stall = busy;
  assign accept     = byte_valid && !byte_stall;

  dnsqp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .msg     (byte_data),
    .cap     (cap_eff),
    .produce (produce),
    .result  (result)
  );

  dnsqp_out u_out (
    .clk          (clk),
    .rst          (rst),
    .produce      (accept && produce),
    .result_in    (result),
    .busy         (busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule

`default_nettype wire

[src/dnsqp_parse.sv]
`timescale 1ns / 1ps
`default_nettype none

module dnsqp_parse (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire dnsqp_pkg::msg_t  msg,
  input  wire logic [8:0]       cap,
  output logic                  produce,
  output dnsqp_pkg::result_t    result
);
  import dnsqp_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  byte_pos, byte_pos_next;
  logic [5:0]  label_left, label_left_next;
  logic [7:0]  name_count, name_count_next;
  logic [15:0] txn_id, txn_id_next;
  logic [15:0] qtype_reg, qtype_reg_next;
  logic [7:0]  qclass_hi, qclass_hi_next;
  status_t     err_code, err_code_next;

  logic        emit;
  logic [7:0]  emit_char;
  logic [7:0]  b;
  logic [8:0]  nc_wide;
  logic [8:0]  nc_dot;
  logic        has_name;

  assign b        = msg.msg_byte;
  assign nc_wide  = {1'b0, name_count};
  assign has_name = (name_count != 8'd0);
  assign nc_dot   = nc_wide + {8'd0, has_name};

  // per-byte parse step
  always_comb begin
    phase_next      = phase;
    byte_pos_next   = byte_pos;
    label_left_next = label_left;
    name_count_next = name_count;
    txn_id_next     = txn_id;
    qtype_reg_next  = qtype_reg;
    qclass_hi_next  = qclass_hi;
    err_code_next   = err_code;
    emit            = 1'b0;
    emit_char       = 8'd0;
    case (phase)
      PH_HEADER: begin
        case (byte_pos)
          HDR_ID_HI: txn_id_next = {b, 8'd0};
          HDR_ID_LO: txn_id_next = {txn_id[15:8], b};
          HDR_FLAGS: if (b[7:3] != 5'd0) err_code_next = ST_INVALID;
          HDR_QD_HI: if (b != 8'd0) err_code_next = ST_INVALID;
          HDR_QD_LO: if (b != 8'd1) err_code_next = ST_INVALID;
          default: ;
        endcase
        if (byte_pos == HDR_LAST) begin
          byte_pos_next = 4'd0;
          phase_next    = (err_code_next != ST_OK) ? PH_DONE : PH_LEN;
        end else begin
          byte_pos_next = byte_pos + 4'd1;
        end
      end
      PH_LEN: begin
        if (b == 8'd0) begin
          if (nc_wide + 9'd1 > cap) begin
            err_code_next = ST_OVF;
            phase_next    = PH_DONE;
          end else begin
            phase_next    = PH_TAIL;
            byte_pos_next = 4'd0;
          end
        end else if (b > 8'(MAX_LABEL)) begin
          err_code_next = ST_TOOLONG;
          phase_next    = PH_DONE;
        end else if (has_name && (nc_wide + 9'd1 >= cap)) begin
          err_code_next = ST_OVF;
          phase_next    = PH_DONE;
        end else begin
          // dot between labels goes out even if this label then overflows
          if (has_name) begin
            emit      = 1'b1;
            emit_char = DOT_CHAR;
          end
          name_count_next = nc_dot[7:0];
          if (nc_dot + {1'b0, b} >= cap) begin
            err_code_next = ST_OVF;
            phase_next    = PH_DONE;
          end else begin
            label_left_next = b[5:0];
            phase_next      = PH_CHARS;
          end
        end
      end
      PH_CHARS: begin
        emit            = 1'b1;
        emit_char       = b;
        name_count_next = name_count + 8'd1;
        if (label_left != 6'd0) label_left_next = label_left - 6'd1;
        if (label_left_next == 6'd0) phase_next = PH_LEN;
      end
      PH_TAIL: begin
        case (byte_pos[1:0])
          TAIL_TYPE_HI:  qtype_reg_next = {b, 8'd0};
          TAIL_TYPE_LO:  qtype_reg_next = {qtype_reg[15:8], b};
          TAIL_CLASS_HI: qclass_hi_next = b;
          TAIL_CLASS_LO: begin
            if ({qclass_hi, b} != CLASS_INET) begin
              err_code_next = ST_INVALID;
            end
            phase_next = PH_DONE;
          end
          default: ;
        endcase
        byte_pos_next = byte_pos + 4'd1;
      end
      default: ;
    endcase
  end

  // result for this request
  always_comb begin
    result  = '0;
    produce = msg.end_of_msg || emit;
    if (msg.end_of_msg) begin
      result.result_kind = KIND_SUMMARY;
      result.name_length = name_count_next;
      result.query_id    = (phase_next == PH_HEADER) ? 16'd0 : txn_id_next;
      result.query_type  = (phase_next == PH_TAIL && byte_pos_next < 4'd2) ?
                           16'd0 : qtype_reg_next;
      result.status      = (phase_next == PH_DONE) ? err_code_next : ST_OVF;
    end else begin
      result.result_kind = KIND_CHAR;
      result.name_char   = emit_char;
    end
  end

  // parser state, cleared after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      byte_pos   <= 4'd0;
      label_left <= 6'd0;
      name_count <= 8'd0;
      txn_id     <= 16'd0;
      qtype_reg  <= 16'd0;
      qclass_hi  <= 8'd0;
      err_code   <= ST_OK;
    end else if (accept) begin
      if (msg.end_of_msg) begin
        phase      <= PH_HEADER;
        byte_pos   <= 4'd0;
        label_left <= 6'd0;
        name_count <= 8'd0;
        txn_id     <= 16'd0;
        qtype_reg  <= 16'd0;
        qclass_hi  <= 8'd0;
        err_code   <= ST_OK;
      end else begin
        phase      <= phase_next;
        byte_pos   <= byte_pos_next;
        label_left <= label_left_next;
        name_count <= name_count_next;
        txn_id     <= txn_id_next;
        qtype_reg  <= qtype_reg_next;
        qclass_hi  <= qclass_hi_next;
        err_code   <= err_code_next;
      end
    end
  end

  // label bytes always have a count behind them
  a_chars_left: assert property (@(posedge clk) disable iff (rst)
    phase == PH_CHARS |-> label_left != 6'd0)
    else $error("label character phase with no bytes left");

  // header offset stays inside the header
  a_hdr_pos: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HEADER |-> byte_pos <= HDR_LAST)
    else $error("header offset past end of header");

  // outside the header, an error is only held once parsing is done
  a_err_done: assert property (@(posedge clk) disable iff (rst)
    (err_code != ST_OK && phase != PH_HEADER) |-> phase == PH_DONE)
    else $error("error code set while still parsing");

endmodule

`default_nettype wire

[src/dnsqp_out.sv]
`timescale 1ns / 1ps
`default_nettype none

module dnsqp_out (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                produce,
  input  wire dnsqp_pkg::result_t  result_in,
  output logic                     busy,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output dnsqp_pkg::result_t       result_data
);
  import dnsqp_pkg::*;

  logic    skid_valid;
  result_t skid_data;

  // requests are refused only while the skid entry is occupied
  assign busy = skid_valid;

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= produce;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || !result_stall) begin
      result_data <= skid_valid ? skid_data : result_in;
    end else if (produce) begin
      skid_data <= result_in;
    end
  end

  // skid entry is only used behind a full output register
  a_skid_behind: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry held with empty output register");

  // skid fills only when the output was stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(result_valid && result_stall))
    else $error("skid entry filled without a stall");

  // no new result while the skid entry is busy
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !produce)
    else $error("result produced while skid entry busy");

endmodule

`default_nettype wire
